FILE: hdl/ffha_pkg.sv
package ffha_pkg;

  // Table geometry
  localparam int MAX_HOLES = 16;
  localparam int SIZE_BITS = 16;

  // Fixed field widths
  localparam int CNT_W   = 5;
  localparam int IDX_W   = 4;
  localparam int AMT_W   = 16;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Register word index
  localparam logic [0:0] REG_HOLES_IN_USE = 1'b0;

  // Item kinds
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  typedef logic [SIZE_BITS-1:0] size_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic  load;
    logic  alloc;
    size_t amount;
  } cell_cmd_t;

endpackage

FILE: hdl/first_fit_hole_allocator.sv
// First-fit hole allocator. A row of MAX_HOLES cells each holds the free
// size of one hole. A load transaction writes one hole's size; an allocate
// transaction takes the request from the lowest-indexed hole among the first
// holes_in_use (register at byte address 0, values above MAX_HOLES act as
// MAX_HOLES) whose size is at least the request, and returns granted, the hole
// index and the space left. A miss returns all zeros and changes nothing;
// loads return all zeros. Each transaction is first captured into the request
// register; once the output register is free, the compare and take-chain runs
// through the cells and the write-back goes into the chosen cell. The next item
// can be accepted while a result waits in the output register. Allocating from
// a hole that was never loaded gives undefined results.
module first_fit_hole_allocator (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [ffha_pkg::IDX_W-1:0]   hole_index,
  input  logic [ffha_pkg::AMT_W-1:0]   amount,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         granted,
  output logic [ffha_pkg::IDX_W-1:0]   chosen_hole,
  output logic [ffha_pkg::AMT_W-1:0]   space_left,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffha_pkg::APB_AW-1:0]  paddr,
  input  logic [ffha_pkg::APB_DW-1:0]  pwdata,
  output logic [ffha_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import ffha_pkg::*;

  state_t                state, state_next;
  logic [CNT_W-1:0]      holes_in_use;
  logic                  req_action;
  logic [IDX_W-1:0]      req_index;
  logic [AMT_W-1:0]      req_amount;
  logic                  in_take;
  logic                  out_free;
  logic                  eval_go;
  cell_cmd_t             cmd;
  logic [MAX_HOLES:0]    taken;
  logic [MAX_HOLES-1:0]  hit;
  size_t                 left   [MAX_HOLES];
  logic [IDX_W-1:0]      sel_idx;
  size_t                 sel_left;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HOLES_IN_USE) ? APB_DW'(holes_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      holes_in_use <= CNT_W'(MAX_HOLES);
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_HOLES_IN_USE) begin
      holes_in_use <= pwdata[CNT_W-1:0];
    end
  end

  // Control: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_take) state_next = ST_BUSY;
      ST_BUSY: if (eval_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control: outputs
  always_comb begin
    in_stall = 1'b1;
    eval_go  = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_BUSY: eval_go  = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_action <= action;
      req_index  <= hole_index;
      req_amount <= amount;
    end
  end

  // Command to the cell row
  always_comb begin
    cmd.load   = eval_go && (req_action == ACT_LOAD);
    cmd.alloc  = eval_go && (req_action == ACT_ALLOC);
    cmd.amount = SIZE_BITS'(req_amount);
  end

  // Cell row with first-fit take chain
  assign taken[0] = 1'b0;

  for (genvar i = 0; i < MAX_HOLES; i++) begin : g_cell
    ffha_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .sel       (32'(req_index) == i),
      .enable    (32'(holes_in_use) > i),
      .taken_in  (taken[i]),
      .taken_out (taken[i+1]),
      .hit       (hit[i]),
      .left      (left[i])
    );
  end

  // Pick index and remainder of the single hitting cell
  always_comb begin
    sel_idx  = '0;
    sel_left = '0;
    for (int i = 0; i < MAX_HOLES; i++) begin
      sel_idx  = sel_idx  | ({IDX_W{hit[i]}} & IDX_W'(i));
      sel_left = sel_left | ({SIZE_BITS{hit[i]}} & left[i]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eval_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_go) begin
      if ((req_action == ACT_ALLOC) && taken[MAX_HOLES]) begin
        granted     <= 1'b1;
        chosen_hole <= sel_idx;
        space_left  <= AMT_W'(sel_left);
      end else begin
        granted     <= 1'b0;
        chosen_hole <= '0;
        space_left  <= '0;
      end
    end
  end

  // Checks; hit is only meaningful while an allocate is evaluated
  a_hit_onehot: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> $onehot0(hit))
    else $error("more than one cell claims the request");

  a_hit_chain: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> ((hit != '0) == taken[MAX_HOLES]))
    else $error("take chain disagrees with hit vector");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_BUSY))
    else $error("accepted item not held for evaluation");

  a_eval_out: assert property (@(posedge clk) disable iff (rst)
    eval_go |=> out_valid)
    else $error("evaluated item produced no result");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (chosen_hole == '0 && space_left == '0))
    else $error("non-granted result carries nonzero fields");

endmodule

FILE: hdl/ffha_cell.sv
module ffha_cell (
  input  logic              clk,
  input  ffha_pkg::cell_cmd_t cmd,
  input  logic              sel,
  input  logic              enable,
  input  logic              taken_in,
  output logic              taken_out,
  output logic              hit,
  output ffha_pkg::size_t   left
);
  import ffha_pkg::*;

  size_t size_q;
  logic  fits;

  // Fit test against the broadcast request
  assign fits      = enable && (size_q >= cmd.amount);
  assign left      = size_q - cmd.amount;
  assign hit       = fits && !taken_in;
  assign taken_out = taken_in || fits;

  // Hole size storage: load or first-fit take
  always_ff @(posedge clk) begin
    if (cmd.load && sel) begin
      size_q <= cmd.amount;
    end else if (cmd.alloc && hit) begin
      size_q <= left;
    end
  end

endmodule

FILE: tb/tb_first_fit_hole_allocator.sv
module tb_first_fit_hole_allocator;
  import ffha_pkg::*;

  localparam int CYCLE_LIMIT  = 250000;
  localparam int DRAIN_CYCLES = 6;
  localparam int BURST_CYCLES = 300;
  localparam logic [APB_AW-1:0] ADDR_HOLES = APB_AW'(4 * REG_HOLES_IN_USE);
  localparam logic [APB_AW-1:0] ADDR_SPARE = ADDR_HOLES + APB_AW'(4);

  // Shadow of the hole table plus the queue of expected results
  class first_fit_checker;
    typedef struct packed {
      logic             granted;
      logic [IDX_W-1:0] hole;
      logic [AMT_W-1:0] left;
    } fit_t;

    size_t            hole_size [MAX_HOLES];
    logic [CNT_W-1:0] holes_in_use;
    fit_t             pending_fits [$];
    int               errors;
    int               grants;
    int               misses;
    int               loads;

    function new();
      foreach (hole_size[i]) hole_size[i] = '0;
      holes_in_use = CNT_W'(16);
      errors = 0;
      grants = 0;
      misses = 0;
      loads  = 0;
    endfunction

    function void set_holes_in_use(logic [CNT_W-1:0] v);
      holes_in_use = v;
    endfunction

    // first-fit search over the holes in use, then write-back
    function void note_item(logic act, logic [IDX_W-1:0] idx, logic [AMT_W-1:0] amt);
      fit_t r;
      int   limit;
      bit   hit;
      r   = '0;
      hit = 1'b0;
      if (act == ACT_LOAD) begin
        hole_size[idx] = size_t'(amt);
        loads++;
      end else begin
        limit = (int'(holes_in_use) > MAX_HOLES) ? MAX_HOLES : int'(holes_in_use);
        for (int j = 0; j < limit; j++) begin
          if (!hit && hole_size[j] >= size_t'(amt)) begin
            hit = 1'b1;
            hole_size[j] = hole_size[j] - size_t'(amt);
            r.granted = 1'b1;
            r.hole    = IDX_W'(j);
            r.left    = AMT_W'(hole_size[j]);
          end
        end
        if (hit) grants++;
        else misses++;
      end
      pending_fits.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic g, logic [IDX_W-1:0] h, logic [AMT_W-1:0] s);
      fit_t e;
      if (pending_fits.size() == 0) begin
        report($sformatf("result with nothing expected (g=%0d hole=%0d left=%0d)", g, h, s));
      end else begin
        e = pending_fits.pop_front();
        if (g !== e.granted) report($sformatf("granted %0d, expected %0d", g, e.granted));
        if (h !== e.hole) report($sformatf("chosen_hole %0d, expected %0d", h, e.hole));
        if (s !== e.left) report($sformatf("space_left %0d, expected %0d", s, e.left));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             in_valid   = 1'b0;
  logic             in_stall;
  logic             action     = ACT_LOAD;
  logic [IDX_W-1:0] hole_index = '0;
  logic [AMT_W-1:0] amount     = '0;

  logic             out_valid;
  logic             out_stall  = 1'b0;
  logic             granted;
  logic [IDX_W-1:0] chosen_hole;
  logic [AMT_W-1:0] space_left;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  first_fit_checker sb = new();

  int          snd_idle   = 19;
  int          rcv_idle   = 61;
  logic        burst_go   = 1'b0;
  bit          burst_done = 1'b0;
  int          burst_left = 0;
  int unsigned cycle_count = 0;

  first_fit_hole_allocator u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .hole_index  (hole_index),
    .amount      (amount),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .granted     (granted),
    .chosen_hole (chosen_hole),
    .space_left  (space_left),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 12-unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cycle counter and watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL first_fit_hole_allocator");
    $finish;
  end

  // Result side: check each accepted transaction, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(granted, chosen_hole, space_left);
    if (burst_go && !burst_done) begin
      burst_done = 1'b1;
      burst_left = BURST_CYCLES;
    end
    if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // Offer one transaction, with an optional random gap first
  task automatic send_item(logic act, logic [IDX_W-1:0] idx, logic [AMT_W-1:0] amt);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_valid   <= 1'b1;
    action     <= act;
    hole_index <= idx;
    amount     <= amt;
    do @(posedge clk); while (in_stall);
    sb.note_item(act, idx, amt);
  endtask

  // Mixed loads and allocates; sizes skewed so both grants and misses occur
  task automatic send_random_items(int n);
    logic             act;
    logic [IDX_W-1:0] idx;
    logic [AMT_W-1:0] amt;
    for (int k = 0; k < n; k++) begin
      idx = IDX_W'($urandom_range(MAX_HOLES - 1));
      if ($urandom_range(99) < 35) begin
        act = ACT_LOAD;
        case ($urandom_range(9))
          0:       amt = '0;
          1:       amt = '1;
          2, 3:    amt = AMT_W'($urandom());
          default: amt = AMT_W'($urandom_range(4000));
        endcase
      end else begin
        act = ACT_ALLOC;
        case ($urandom_range(9))
          0:       amt = '0;
          1:       amt = '1;
          2:       amt = AMT_W'($urandom());
          default: amt = AMT_W'($urandom_range(1200));
        endcase
      end
      send_item(act, idx, amt);
    end
  endtask

  // Drop valid and let every expected result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_fits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup and access phases, then the bus is left idle before returning
  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_HOLES) sb.set_holes_in_use(data[CNT_W-1:0]);
    @(posedge clk);
  endtask

  task automatic apb_read(logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write holes_in_use (noise in the upper bits) and read it back
  task automatic set_holes(logic [CNT_W-1:0] v);
    logic [APB_DW-1:0] rd;
    wait_idle();
    apb_write(ADDR_HOLES, ($urandom() & ~APB_DW'({CNT_W{1'b1}})) | APB_DW'(v));
    apb_read(ADDR_HOLES, rd);
    if (rd[CNT_W-1:0] !== sb.holes_in_use)
      sb.report($sformatf("holes_in_use reads %0d, expected %0d", rd[CNT_W-1:0],
                          sb.holes_in_use));
    @(posedge clk);
  endtask

  initial begin : main
    logic [APB_DW-1:0] rd;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: load every hole first, holes_in_use still at its reset value
    send_item(ACT_LOAD, 4'd0, 16'd10);
    send_item(ACT_LOAD, 4'd1, 16'd0);
    send_item(ACT_LOAD, 4'd2, 16'd300);
    send_item(ACT_LOAD, 4'd3, 16'hFFFF);
    for (int i = 4; i < MAX_HOLES - 1; i++)
      send_item(ACT_LOAD, IDX_W'(i), AMT_W'(i * 256));
    send_item(ACT_LOAD, 4'd15, 16'hFFFF);

    // zero request takes the first hole and leaves it unchanged
    send_item(ACT_ALLOC, 4'd15, 16'd0);
    // exact fit empties hole 0
    send_item(ACT_ALLOC, 4'd0, 16'd10);
    // largest request, hole_index field must be ignored
    send_item(ACT_ALLOC, 4'd9, 16'hFFFF);
    send_item(ACT_ALLOC, 4'd0, 16'hFFFF);
    // nothing left that large: miss
    send_item(ACT_ALLOC, 4'd0, 16'hFFFF);
    send_item(ACT_ALLOC, 4'd0, 16'd1);

    // zero holes searched: every allocate misses
    set_holes('0);
    send_item(ACT_ALLOC, 4'd0, 16'd0);
    send_item(ACT_ALLOC, 4'd0, 16'd5);

    // value above the table size saturates
    set_holes('1);
    send_item(ACT_ALLOC, 4'd0, 16'd20000);
    send_item(ACT_LOAD, 4'd15, 16'd40000);
    send_item(ACT_ALLOC, 4'd0, 16'd20000);

    // single hole searched
    set_holes(CNT_W'(1));
    send_item(ACT_ALLOC, 4'd0, 16'd0);
    send_item(ACT_ALLOC, 4'd0, 16'd1);

    // write to an unmapped register must not disturb holes_in_use
    wait_idle();
    apb_write(ADDR_SPARE, $urandom());
    apb_read(ADDR_HOLES, rd);
    if (rd[CNT_W-1:0] !== sb.holes_in_use)
      sb.report($sformatf("holes_in_use reads %0d after unmapped write, expected %0d",
                          rd[CNT_W-1:0], sb.holes_in_use));
    @(posedge clk);

    // Random, sender idles lightly, receiver heavily
    set_holes(CNT_W'($urandom_range(2, MAX_HOLES)));
    send_random_items(600);

    // Random, roles swapped, saturating holes_in_use
    snd_idle = 61;
    rcv_idle <= 19;
    set_holes(CNT_W'($urandom_range(MAX_HOLES + 1, 31)));
    send_random_items(600);

    // Random, no idling, with one long receiver hold-off to back up the input
    snd_idle = 0;
    rcv_idle <= 0;
    set_holes(CNT_W'(MAX_HOLES));
    send_random_items(50);
    burst_go <= 1'b1;
    send_random_items(500);

    wait_idle();
    if (sb.pending_fits.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_fits.size()));

    $display("Checked %0d loads, %0d grants and %0d misses", sb.loads, sb.grants, sb.misses);
    $display("holes_in_use swept 0, 1, 16, saturated and random; three idle mixes");
    if (sb.errors == 0) begin
      $display("PASS first_fit_hole_allocator");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL first_fit_hole_allocator");
    end
    $finish;
  end

endmodule
